### design/line_plane_intersect_macros.svh
// Assertion helpers shared by the checker.
`ifndef LINE_PLANE_INTERSECT_MACROS_SVH
`define LINE_PLANE_INTERSECT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define LPI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpi check failed");

// Next-cycle implication, gated off during reset.
`define LPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpi check failed");

`endif

### design/lpi_pkg.sv
package lpi_pkg;

  typedef enum logic [2:0] {
    REG_NX  = 3'd0,
    REG_NY  = 3'd1,
    REG_NZ  = 3'd2,
    REG_D   = 3'd3,
    REG_TOL = 3'd4
  } lpi_reg_t;

  typedef enum logic [1:0] {
    FUNC_RAY  = 2'd0,
    FUNC_LINE = 2'd1,
    FUNC_SEG  = 2'd2,
    FUNC_NONE = 2'd3
  } lpi_func_t;

  // Side data that travels with a beat through the divider chain.
  typedef struct packed {
    lpi_func_t          func;
    logic               miss;
    logic               neg;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } lpi_pay_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = S32_MAX;
    else if (v < -66'sh0_8000_0000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### design/line_plane_intersect.sv
// Channel   | Signals                                   | Beat taken when
// ----------+-------------------------------------------+-----------------------
// query in  | start, busy, func, start_*, second_*      | start && !busy
// result    | done, hit, hit_x, hit_y, hit_z            | every cycle done is high
// config    | cfg_we, cfg_index, cfg_data               | cfg_we
//
// One query enters per cycle while busy is low; each gives one result.
// The divider is a row of 32 + FRAC_BITS cells, one quotient bit each.
// busy is high only during reset; rst is synchronous and clears all valid flags.
// The result side has no back pressure: done pulses for one cycle per beat.
module line_plane_intersect import lpi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_z,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [31:0] hit_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Quotient width: |num| <= 2^31, scaled up by 2^FRAC_BITS.
  localparam int QW = 32 + FRAC_BITS;
  localparam logic [QW-1:0] T_ONE = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] T_POS_LIM = QW'(32'h7FFF_FFFF);
  localparam logic [QW-1:0] T_NEG_LIM = QW'(33'h1_0000_0000 >> 1);

  assign busy = rst;

  // ---------------- configuration registers ----------------
  logic signed [31:0] normal_x, normal_y, normal_z, plane_offset;
  logic [15:0]        zero_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x       <= '0;
      normal_y       <= '0;
      normal_z       <= 32'(1) << FRAC_BITS;
      plane_offset   <= '0;
      zero_tolerance <= 16'd1;
    end else if (cfg_we) begin
      unique case (lpi_reg_t'(cfg_index))
        REG_NX:  normal_x       <= cfg_data;
        REG_NY:  normal_y       <= cfg_data;
        REG_NZ:  normal_z       <= cfg_data;
        REG_D:   plane_offset   <= cfg_data;
        REG_TOL: zero_tolerance <= cfg_data[15:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- s0: capture, direction ----------------
  logic     s0_valid;
  lpi_pay_t s0_pay, s0_pay_next;
  logic     in_beat;

  assign in_beat = start && !busy;

  always_comb begin
    s0_pay_next      = '0;
    s0_pay_next.func = lpi_func_t'(func);
    s0_pay_next.miss = (lpi_func_t'(func) == FUNC_NONE);
    s0_pay_next.sx   = start_x;
    s0_pay_next.sy   = start_y;
    s0_pay_next.sz   = start_z;
    if (lpi_func_t'(func) == FUNC_RAY) begin
      s0_pay_next.dx = second_x;
      s0_pay_next.dy = second_y;
      s0_pay_next.dz = second_z;
    end else begin
      // end point minus start point, saturated
      s0_pay_next.dx = sat32(66'(second_x) - 66'(start_x));
      s0_pay_next.dy = sat32(66'(second_y) - 66'(start_y));
      s0_pay_next.dz = sat32(66'(second_z) - 66'(start_z));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else     s0_valid <= in_beat;
    s0_pay <= s0_pay_next;
  end

  // ---------------- s1: six products, floor-shifted ----------------
  logic               s1_valid;
  lpi_pay_t           s1_pay;
  logic signed [63:0] s1_pdx, s1_pdy, s1_pdz, s1_psx, s1_psy, s1_psz;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= s0_valid;
    s1_pay <= s0_pay;
    // arithmetic shift right = floor
    s1_pdx <= (64'(normal_x) * 64'(s0_pay.dx)) >>> FRAC_BITS;
    s1_pdy <= (64'(normal_y) * 64'(s0_pay.dy)) >>> FRAC_BITS;
    s1_pdz <= (64'(normal_z) * 64'(s0_pay.dz)) >>> FRAC_BITS;
    s1_psx <= (64'(normal_x) * 64'(s0_pay.sx)) >>> FRAC_BITS;
    s1_psy <= (64'(normal_y) * 64'(s0_pay.sy)) >>> FRAC_BITS;
    s1_psz <= (64'(normal_z) * 64'(s0_pay.sz)) >>> FRAC_BITS;
  end

  // ---------------- s2: dot-product sums ----------------
  logic               s2_valid;
  lpi_pay_t           s2_pay;
  logic signed [31:0] s2_den, s2_nsum;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_pay  <= s1_pay;
    s2_den  <= sat32(66'(s1_pdx) + 66'(s1_pdy) + 66'(s1_pdz));
    s2_nsum <= sat32(66'(s1_psx) + 66'(s1_psy) + 66'(s1_psz));
  end

  // ---------------- s3: numerator, tolerance, divider operands ----------------
  logic               s3_valid;
  lpi_pay_t           s3_pay, s3_pay_next;
  logic [31:0]        s3_div, abs_num, abs_den;
  logic [QW-1:0]      s3_quo;
  logic signed [31:0] num;
  logic [32:0]        neg_num33, neg_den33;

  always_comb begin
    num       = sat32(66'(s2_nsum) + 66'(plane_offset));
    neg_num33 = -33'(num);
    neg_den33 = -33'(s2_den);
    abs_num   = num[31]    ? neg_num33[31:0] : num;
    abs_den   = s2_den[31] ? neg_den33[31:0] : s2_den;
    s3_pay_next      = s2_pay;
    // quotient of -num / den is negative when num and den share a sign
    s3_pay_next.neg  = (num > 32'sd0) ^ s2_den[31];
    s3_pay_next.miss = s2_pay.miss || (abs_den <= {16'd0, zero_tolerance});
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_pay <= s3_pay_next;
    s3_div <= abs_den;
    s3_quo <= {abs_num, {FRAC_BITS{1'b0}}};
  end

  // ---------------- divider: row of cells ----------------
  logic          c_valid [QW+1];
  lpi_pay_t      c_pay   [QW+1];
  logic [31:0]   c_rem   [QW+1];
  logic [QW-1:0] c_quo   [QW+1];
  logic [31:0]   c_div   [QW+1];

  assign c_valid[0] = s3_valid;
  assign c_pay[0]   = s3_pay;
  assign c_rem[0]   = '0;
  assign c_quo[0]   = s3_quo;
  assign c_div[0]   = s3_div;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    lpi_div_cell #(.QW(QW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_pay    (c_pay[i]),
      .in_rem    (c_rem[i]),
      .in_quo    (c_quo[i]),
      .in_div    (c_div[i]),
      .out_valid (c_valid[i+1]),
      .out_pay   (c_pay[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_quo   (c_quo[i+1]),
      .out_div   (c_div[i+1])
    );
  end

  // ---------------- s4: sign, range tests, saturation of t ----------------
  logic               s4_valid;
  lpi_pay_t           s4_pay, s4_pay_next;
  logic signed [31:0] s4_t, t_next;
  logic [QW-1:0]      q;
  logic               t_neg;

  always_comb begin
    q           = c_quo[QW];
    t_neg       = c_pay[QW].neg && (q != '0);
    s4_pay_next = c_pay[QW];
    case (c_pay[QW].func)
      FUNC_RAY: s4_pay_next.miss = c_pay[QW].miss || t_neg;
      FUNC_SEG: s4_pay_next.miss = c_pay[QW].miss || t_neg ||
                                   (!c_pay[QW].neg && q > T_ONE);
      default:  s4_pay_next.miss = c_pay[QW].miss;
    endcase
    if (!c_pay[QW].neg) begin
      t_next = (q > T_POS_LIM) ? S32_MAX : q[31:0];
    end else begin
      t_next = (q > T_NEG_LIM) ? S32_MIN : -q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= c_valid[QW];
    s4_pay <= s4_pay_next;
    s4_t   <= t_next;
  end

  // ---------------- s5: dir * t ----------------
  logic               s5_valid;
  lpi_pay_t           s5_pay;
  logic signed [63:0] s5_px, s5_py, s5_pz;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else     s5_valid <= s4_valid;
    s5_pay <= s4_pay;
    s5_px  <= (64'(s4_pay.dx) * 64'(s4_t)) >>> FRAC_BITS;
    s5_py  <= (64'(s4_pay.dy) * 64'(s4_t)) >>> FRAC_BITS;
    s5_pz  <= (64'(s4_pay.dz) * 64'(s4_t)) >>> FRAC_BITS;
  end

  // ---------------- s6: point, output register ----------------
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s5_valid;
    hit <= !s5_pay.miss;
    if (s5_pay.miss) begin
      hit_x <= '0;
      hit_y <= '0;
      hit_z <= '0;
    end else begin
      hit_x <= sat32(66'(s5_pay.sx) + 66'(s5_px));
      hit_y <= sat32(66'(s5_pay.sy) + 66'(s5_py));
      hit_z <= sat32(66'(s5_pay.sz) + 66'(s5_pz));
    end
  end

endmodule

### design/lpi_div_cell.sv
// One restoring-division step: one quotient bit per cell.
module lpi_div_cell import lpi_pkg::*; #(
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lpi_pay_t      in_pay,
  input  logic [31:0]   in_rem,
  input  logic [QW-1:0] in_quo,
  input  logic [31:0]   in_div,
  output logic          out_valid,
  output lpi_pay_t      out_pay,
  output logic [31:0]   out_rem,
  output logic [QW-1:0] out_quo,
  output logic [31:0]   out_div
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial = {in_rem, in_quo[QW-1]};
    diff  = trial - {1'b0, in_div};
    ge    = (trial >= {1'b0, in_div});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_pay <= in_pay;
    out_div <= in_div;
    out_rem <= ge ? diff[31:0] : trial[31:0];
    out_quo <= {in_quo[QW-2:0], ge};
  end

endmodule

### design/lpi_checker.sv
`include "line_plane_intersect_macros.svh"

// Port-level checks on the intersect block.
module lpi_checker import lpi_pkg::*; #(
  parameter int LAT = 55
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func,
  input logic        done,
  input logic        hit,
  input logic [31:0] hit_x,
  input logic [31:0] hit_y,
  input logic [31:0] hit_z
);

  // every result beat comes from a query beat a fixed latency earlier
  `LPI_ASSERT_NOW(a_done_from_query, clk, rst, done, $past(start && !busy, LAT))

  // a miss carries a zero point
  `LPI_ASSERT_NOW(a_miss_zero, clk, rst, done && !hit,
                  hit_x == 32'd0 && hit_y == 32'd0 && hit_z == 32'd0)

  // the unused query kind never hits
  `LPI_ASSERT_NOW(a_unused_kind_miss, clk, rst,
                  done && $past(start && !busy && func == FUNC_NONE, LAT), !hit)

  // a query beat always produces a result beat
  `LPI_ASSERT_NOW(a_query_gives_done, clk, rst,
                  $past(start && !busy, LAT) && !$past(rst, LAT - 1) && !rst, done)

endmodule

bind line_plane_intersect lpi_checker #(.LAT(FRAC_BITS + 39)) u_lpi_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done),
  .hit   (hit),
  .hit_x (hit_x),
  .hit_y (hit_y),
  .hit_z (hit_z)
);
